>>> design/dlle_pkg.sv
`default_nettype none

package dlle_pkg;

  localparam int HANDLE_W = 7;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_AFTER  = 3'd0,
    OP_INS_BEFORE = 3'd1,
    OP_ERASE      = 3'd2,
    OP_DUMP       = 3'd3,
    OP_CLEAR      = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_BAD_HANDLE = 2'd2,
    ST_EMPTY      = 2'd3
  } status_e;

  // where the link/value memories are read from
  typedef enum logic [1:0] {
    RD_PORT = 2'd0,
    RD_HEAD = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_e;

  // link memory write pattern for one cycle
  typedef enum logic [2:0] {
    LNK_NONE    = 3'd0,
    LNK_NEWNODE = 3'd1,
    LNK_SPLICE  = 3'd2,
    LNK_UNLINK  = 3'd3,
    LNK_SENT    = 3'd4
  } link_op_e;

  typedef struct packed {
    logic     accept;
    logic     ins_after;
    logic     alloc;
    logic     rd_en;
    rd_sel_e  rd_sel;
    link_op_e link_op;
    logic     emit;
    status_e  emit_status;
    logic     emit_handle;
    logic     emit_value;
    logic     emit_last;
  } dlle_cmd_t;

  typedef struct packed {
    logic ins_bad;
    logic era_bad;
    logic full;
    logic next_zero;
    logic out_free;
  } dlle_stat_t;

endpackage

`default_nettype wire

>>> design/dlle_ctrl.sv
`default_nettype none

module dlle_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic [dlle_pkg::OP_W-1:0]       opcode_i,
  input  dlle_pkg::dlle_stat_t            stat_i,
  output logic                            in_stall_o,
  output dlle_pkg::dlle_cmd_t             cmd_o
);

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_LINK1  = 9'b000000100,
    S_LINK2  = 9'b000001000,
    S_UNLINK = 9'b000010000,
    S_DHEAD  = 9'b000100000,
    S_DUMP   = 9'b001000000,
    S_CLEAR  = 9'b010000000,
    S_RESP   = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  dlle_pkg::status_e rstat_q, rstat_d;
  logic              use_h_q, use_h_d;
  logic              use_v_q, use_v_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    rstat_d = rstat_q;
    use_h_d = use_h_q;
    use_v_d = use_v_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.link_op = dlle_pkg::LNK_SENT;
        state_d       = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept    = 1'b1;
          cmd_o.ins_after = (opcode_i == dlle_pkg::OP_INS_AFTER);
          rstat_d         = dlle_pkg::ST_OK;
          use_h_d         = 1'b0;
          use_v_d         = 1'b0;
          unique case (opcode_i) inside
            dlle_pkg::OP_INS_AFTER, dlle_pkg::OP_INS_BEFORE: begin
              if (stat_i.ins_bad) begin
                rstat_d = dlle_pkg::ST_BAD_HANDLE;
                state_d = S_RESP;
              end else if (stat_i.full) begin
                rstat_d = dlle_pkg::ST_FULL;
                state_d = S_RESP;
              end else begin
                cmd_o.alloc  = 1'b1;
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = dlle_pkg::RD_PORT;
                state_d      = S_LINK1;
              end
            end
            dlle_pkg::OP_ERASE: begin
              if (stat_i.era_bad) begin
                rstat_d = dlle_pkg::ST_BAD_HANDLE;
                state_d = S_RESP;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = dlle_pkg::RD_PORT;
                state_d      = S_UNLINK;
              end
            end
            dlle_pkg::OP_DUMP: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = dlle_pkg::RD_HEAD;
              state_d      = S_DHEAD;
            end
            dlle_pkg::OP_CLEAR: begin
              state_d = S_CLEAR;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_LINK1: begin
        cmd_o.link_op = dlle_pkg::LNK_NEWNODE;
        state_d       = S_LINK2;
      end
      S_LINK2: begin
        cmd_o.link_op = dlle_pkg::LNK_SPLICE;
        use_h_d       = 1'b1;
        state_d       = S_RESP;
      end
      S_UNLINK: begin
        cmd_o.link_op = dlle_pkg::LNK_UNLINK;
        use_v_d       = 1'b1;
        state_d       = S_RESP;
      end
      S_DHEAD: begin
        if (stat_i.next_zero) begin
          rstat_d = dlle_pkg::ST_EMPTY;
          state_d = S_RESP;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = dlle_pkg::RD_NEXT;
          state_d      = S_DUMP;
        end
      end
      S_DUMP: begin
        // read data holds until the element is handed to the output register
        if (stat_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = dlle_pkg::ST_OK;
          cmd_o.emit_value  = 1'b1;
          cmd_o.emit_last   = stat_i.next_zero;
          if (stat_i.next_zero) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = dlle_pkg::RD_NEXT;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.link_op = dlle_pkg::LNK_SENT;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = rstat_q;
          cmd_o.emit_handle = use_h_q;
          cmd_o.emit_value  = use_v_q;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      rstat_q <= dlle_pkg::ST_OK;
      use_h_q <= 1'b0;
      use_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rstat_q <= rstat_d;
      use_h_q <= use_h_d;
      use_v_q <= use_v_d;
    end
  end

endmodule

`default_nettype wire

>>> design/dlle_datapath.sv
`default_nettype none

module dlle_datapath #(
  parameter int POOL_NODES = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic        [dlle_pkg::HANDLE_W-1:0]  target_handle_i,
  input  logic signed [dlle_pkg::DATA_W-1:0]    new_value_i,
  input  dlle_pkg::dlle_cmd_t                   cmd_i,
  output dlle_pkg::dlle_stat_t                  stat_o,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic        [dlle_pkg::STATUS_W-1:0]  status_o,
  output logic        [dlle_pkg::HANDLE_W-1:0]  result_handle_o,
  output logic signed [dlle_pkg::DATA_W-1:0]    result_value_o,
  output logic                                  last_of_run_o
);

  localparam int HW    = dlle_pkg::HANDLE_W;
  localparam int DW    = dlle_pkg::DATA_W;
  localparam int Depth = POOL_NODES + 1;
  localparam int AddrW = $clog2(Depth);
  localparam logic [HW-1:0] PoolMax = HW'(POOL_NODES);

  logic [HW-1:0]         next_mem  [Depth];
  logic [HW-1:0]         prev_mem  [Depth];
  logic [VALUE_BITS-1:0] value_mem [Depth];

  logic                  ins_after_q;
  logic [HW-1:0]         tgt_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [HW-1:0]         nh_q;
  logic [HW-1:0]         used_q;
  logic [Depth-1:0]      live_q;
  logic [HW-1:0]         rd_next_q;
  logic [HW-1:0]         rd_prev_q;
  logic [VALUE_BITS-1:0] rd_val_q;

  logic                  out_valid_q;
  logic [dlle_pkg::STATUS_W-1:0] status_q;
  logic [HW-1:0]         handle_q;
  logic [DW-1:0]         value_q;
  logic                  last_q;

  logic [VALUE_BITS-1:0] val_in;
  logic [DW-1:0]         val_out;
  logic [AddrW-1:0]      rd_addr;
  logic                  tgt_in_range;
  logic                  tgt_live;
  logic                  out_free;
  logic [HW-1:0]         node_a;
  logic [HW-1:0]         node_b;
  logic                  next_we;
  logic                  prev_we;
  logic                  val_we;
  logic [AddrW-1:0]      next_waddr;
  logic [AddrW-1:0]      prev_waddr;
  logic [HW-1:0]         next_wdata;
  logic [HW-1:0]         prev_wdata;

  // stored values are masked to VALUE_BITS, results to the port width
  if (VALUE_BITS >= DW) begin : g_wide
    assign val_in  = VALUE_BITS'($unsigned(new_value_i));
    assign val_out = rd_val_q[DW-1:0];
  end else begin : g_narrow
    assign val_in  = new_value_i[VALUE_BITS-1:0];
    assign val_out = {{(DW - VALUE_BITS){1'b0}}, rd_val_q};
  end

  assign tgt_in_range = (target_handle_i <= PoolMax);
  assign tgt_live     = tgt_in_range && live_q[target_handle_i[AddrW-1:0]];
  assign out_free     = !out_valid_q || !out_stall_i;

  assign stat_o.ins_bad   = (target_handle_i != '0) && !tgt_live;
  assign stat_o.era_bad   = !tgt_live;
  assign stat_o.full      = (used_q >= PoolMax);
  assign stat_o.next_zero = (rd_next_q == '0);
  assign stat_o.out_free  = out_free;

  always_comb begin
    unique case (cmd_i.rd_sel)
      dlle_pkg::RD_PORT: rd_addr = target_handle_i[AddrW-1:0];
      dlle_pkg::RD_HEAD: rd_addr = '0;
      dlle_pkg::RD_NEXT: rd_addr = rd_next_q[AddrW-1:0];
      default:           rd_addr = '0;
    endcase
  end

  // neighbors of the new node: a before it, b after it
  assign node_a = ins_after_q ? tgt_q : rd_prev_q;
  assign node_b = ins_after_q ? rd_next_q : tgt_q;

  always_comb begin
    next_we    = 1'b0;
    prev_we    = 1'b0;
    val_we     = 1'b0;
    next_waddr = '0;
    prev_waddr = '0;
    next_wdata = '0;
    prev_wdata = '0;
    unique case (cmd_i.link_op)
      dlle_pkg::LNK_NONE: begin
        next_we = 1'b0;
      end
      dlle_pkg::LNK_NEWNODE: begin
        next_we    = 1'b1;
        prev_we    = 1'b1;
        val_we     = 1'b1;
        next_waddr = nh_q[AddrW-1:0];
        prev_waddr = nh_q[AddrW-1:0];
        next_wdata = node_b;
        prev_wdata = node_a;
      end
      dlle_pkg::LNK_SPLICE: begin
        next_we    = 1'b1;
        prev_we    = 1'b1;
        next_waddr = node_a[AddrW-1:0];
        prev_waddr = node_b[AddrW-1:0];
        next_wdata = nh_q;
        prev_wdata = nh_q;
      end
      dlle_pkg::LNK_UNLINK: begin
        next_we    = 1'b1;
        prev_we    = 1'b1;
        next_waddr = rd_prev_q[AddrW-1:0];
        prev_waddr = rd_next_q[AddrW-1:0];
        next_wdata = rd_next_q;
        prev_wdata = rd_prev_q;
      end
      dlle_pkg::LNK_SENT: begin
        // sentinel points to itself
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      default: begin
        next_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (cmd_i.rd_en) begin
      rd_next_q <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (cmd_i.rd_en) begin
      rd_prev_q <= prev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      value_mem[nh_q[AddrW-1:0]] <= val_q;
    end
    if (cmd_i.rd_en) begin
      rd_val_q <= value_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ins_after_q <= cmd_i.ins_after;
      tgt_q       <= target_handle_i;
      val_q       <= val_in;
      nh_q        <= used_q + HW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      used_q <= '0;
    end else if (cmd_i.link_op == dlle_pkg::LNK_SENT) begin
      live_q <= '0;
      used_q <= '0;
    end else begin
      if (cmd_i.alloc) begin
        used_q <= used_q + HW'(1);
      end
      if (cmd_i.link_op == dlle_pkg::LNK_NEWNODE) begin
        live_q[nh_q[AddrW-1:0]] <= 1'b1;
      end
      if (cmd_i.link_op == dlle_pkg::LNK_UNLINK) begin
        live_q[tgt_q[AddrW-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= cmd_i.emit_status;
      handle_q <= cmd_i.emit_handle ? nh_q : '0;
      value_q  <= cmd_i.emit_value ? val_out : '0;
      last_q   <= cmd_i.emit_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign result_handle_o = handle_q;
  assign result_value_o  = value_q;
  assign last_of_run_o   = last_q;

endmodule

`default_nettype wire

>>> design/doubly_linked_list_engine_core.sv
// circular doubly linked list kept in a node pool, sentinel head at handle 0
// request channel: in_valid_i / in_stall_o with opcode_i, target_handle_i,
// new_value_i; result channel: out_valid_o / out_stall_i with status_o,
// result_handle_o, result_value_o, last_of_run_o
// a request is taken only while the controller is idle; in_stall_o is high
// otherwise. handles are given out in order from 1 and come back on clear
// insert: read the neighbor on accept, write the new node, splice the
// neighbors, load the output register; erase unlinks and clear rewrites the
// sentinel before their result; the next request follows the loaded result
// dump: the head is read on accept, then one element per cycle while the
// output is not stalled, paced by the single read port of the link memory;
// empty list gives one result; opcodes 5 to 7 are taken and give nothing
// after reset the sentinel entry is written while in_stall_o is high
// results sit in an output register; while out_stall_i is high it holds its
// payload and the controller waits, so a dump pauses without losing elements
`default_nettype none

module doubly_linked_list_engine_core #(
  parameter int POOL_NODES = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic        [dlle_pkg::OP_W-1:0]      opcode_i,
  input  logic        [dlle_pkg::HANDLE_W-1:0]  target_handle_i,
  input  logic signed [dlle_pkg::DATA_W-1:0]    new_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic        [dlle_pkg::STATUS_W-1:0]  status_o,
  output logic        [dlle_pkg::HANDLE_W-1:0]  result_handle_o,
  output logic signed [dlle_pkg::DATA_W-1:0]    result_value_o,
  output logic                                  last_of_run_o
);

  dlle_pkg::dlle_cmd_t  cmd;
  dlle_pkg::dlle_stat_t stat;

  dlle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  dlle_datapath #(
    .POOL_NODES (POOL_NODES),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .target_handle_i (target_handle_i),
    .new_value_i     (new_value_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .result_handle_o (result_handle_o),
    .result_value_o  (result_value_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

`default_nettype wire

>>> design/dlle_checker.sv
`default_nettype none

module dlle_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic        [dlle_pkg::OP_W-1:0]      opcode_i,
  input logic        [dlle_pkg::HANDLE_W-1:0]  target_handle_i,
  input logic signed [dlle_pkg::DATA_W-1:0]    new_value_i,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic        [dlle_pkg::STATUS_W-1:0]  status_o,
  input logic        [dlle_pkg::HANDLE_W-1:0]  result_handle_o,
  input logic signed [dlle_pkg::DATA_W-1:0]    result_value_o,
  input logic                                  last_of_run_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(result_handle_o) && $stable(result_value_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // error and empty results are single, with no handle and no value
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != dlle_pkg::ST_OK)
      |-> last_of_run_o && (result_handle_o == '0) && (result_value_o == '0))
    else $error("error result carries payload or is not last");

  // a new handle only comes with a successful insert
  a_handle_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_handle_o != '0)
      |-> (status_o == dlle_pkg::ST_OK) && last_of_run_o && (result_value_o == '0))
    else $error("handle returned on a non-insert result");

  // every real operation keeps the engine busy after it is taken
  a_busy_after_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o
      && (opcode_i == dlle_pkg::OP_INS_AFTER || opcode_i == dlle_pkg::OP_INS_BEFORE
          || opcode_i == dlle_pkg::OP_ERASE || opcode_i == dlle_pkg::OP_DUMP
          || opcode_i == dlle_pkg::OP_CLEAR)
      |=> in_stall_o)
    else $error("request taken while an operation was in progress");

endmodule

bind doubly_linked_list_engine_core dlle_checker u_dlle_checker (.*);

`default_nettype wire
